// ----- rtl/prc_pkg.sv -----
// Shared types, constants and the color conversion for the palette RAM block.
`timescale 1ns / 1ps

package prc_pkg;

    // Fixed field widths
    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 32;
    localparam int COLOR_W = 5;
    localparam int BYTE_W  = 8;

    // Default palette size in bytes
    localparam int PALETTE_BYTES_DEF = 8192;

    // Access codes
    typedef enum logic [2:0] {
        FN_WR8  = 3'd0,
        FN_WR16 = 3'd1,
        FN_WR32 = 3'd2,
        FN_RD8  = 3'd3,
        FN_RD16 = 3'd4,
        FN_RD32 = 3'd5
    } t_func;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_WRITE,
        ST_READ,
        ST_RFIN,
        ST_EREQ,
        ST_EHI,
        ST_ELO
    } t_state;

    // One result beat
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               color_valid;
        logic [ADDR_W-1:0]  entry_addr;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } t_result;

    // 4-bit nibbles widened to 5 bits; bits 12..14 fill the low bits
    function automatic logic [3*COLOR_W-1:0] conv_color(input logic [15:0] a);
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        r = {a[3:0],  a[12]};
        g = {a[7:4],  a[13]};
        b = {a[11:8], a[14]};
        return {r, g, b};
    endfunction

endpackage

// ----- rtl/prc_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module prc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read on one port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ----- rtl/prc_alu.sv -----
// Shared index unit: add with wrap at the palette size.
`timescale 1ns / 1ps

module prc_alu #(
    parameter int PALETTE_BYTES = 8192,
    parameter int W             = 14
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_sum,
    output logic         o_wrap
);

    localparam logic [W:0] LIMIT = (W+1)'(PALETTE_BYTES);

    logic [W:0] sum;
    logic [W:0] diff;

    // One add, one compare, one subtract
    always_comb begin
        sum    = {1'b0, i_a} + {1'b0, i_b};
        diff   = sum - LIMIT;
        o_wrap = (sum >= LIMIT);
        o_sum  = o_wrap ? diff[W-1:0] : sum[W-1:0];
    end

endmodule

// ----- rtl/prc_ctrl.sv -----
// Sequencer and datapath: clear pass, byte accesses and entry conversion.
`timescale 1ns / 1ps

module prc_ctrl #(
    parameter int AW            = 13,
    parameter int CW            = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [2:0]                  i_func,
    input  logic [prc_pkg::ADDR_W-1:0]  i_byte_addr,
    input  logic [prc_pkg::DATA_W-1:0]  i_write_data,
    output logic                        busy,
    // shared index unit
    output logic [CW-1:0]               o_alu_a,
    output logic [CW-1:0]               o_alu_b,
    input  logic [CW-1:0]               i_alu_sum,
    input  logic                        i_alu_wrap,
    // palette RAM port
    output logic                        o_ram_we,
    output logic [AW-1:0]               o_ram_addr,
    output logic [prc_pkg::BYTE_W-1:0]  o_ram_wdata,
    input  logic [prc_pkg::BYTE_W-1:0]  i_ram_rdata,
    // result beat
    output logic                        o_valid,
    output prc_pkg::t_result            o_res
);

    import prc_pkg::*;

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [DATA_W-1:0] r_data, n_data;
    logic [CW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_start, n_start;
    logic [AW-1:0]     r_ent, n_ent;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_second, n_second;
    logic [BYTE_W-1:0] r_hi, n_hi;
    logic              r_valid, n_valid;
    t_result           r_res, n_res;

    logic              accept;
    logic              is_write;
    logic [CW-1:0]     ent_wide;
    logic [3*COLOR_W-1:0] rgb;

    assign accept   = start && (r_state == ST_IDLE) && (i_func <= FN_RD32);
    assign is_write = (r_func == FN_WR8) || (r_func == FN_WR16) || (r_func == FN_WR32);
    assign ent_wide = CW'(r_ent);
    assign rgb      = conv_color({r_hi, i_ram_rdata});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (i_alu_wrap) n_state = ST_IDLE;
            ST_IDLE:   if (accept) n_state = ST_REDUCE;
            ST_REDUCE: if (!i_alu_wrap) n_state = is_write ? ST_WRITE : ST_READ;
            ST_WRITE:  if (r_cnt == 3'd1) n_state = ST_EREQ;
            ST_READ:   if (r_cnt == 3'd1) n_state = ST_RFIN;
            ST_RFIN:   n_state = ST_IDLE;
            ST_EREQ:   n_state = ST_EHI;
            ST_EHI:    n_state = ST_ELO;
            ST_ELO:    n_state = ((r_func == FN_WR32) && !r_second) ? ST_EREQ : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath, RAM and index-unit controls
    always_comb begin
        n_func      = r_func;
        n_data      = r_data;
        n_addr      = r_addr;
        n_ptr       = r_ptr;
        n_start     = r_start;
        n_ent       = r_ent;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_second    = r_second;
        n_hi        = r_hi;
        n_valid     = 1'b0;
        n_res       = r_res;
        o_alu_a     = CW'(r_ptr);
        o_alu_b     = CW'(1'b1);
        o_ram_we    = 1'b0;
        o_ram_addr  = r_ptr;
        o_ram_wdata = r_data[DATA_W-1 -: BYTE_W];

        unique case (r_state)
            // zero the store one byte per cycle
            ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '0;
                n_ptr       = i_alu_sum[AW-1:0];
            end
            // latch the access, left-align write bytes
            ST_IDLE: begin
                if (accept) begin
                    n_func   = t_func'(i_func);
                    n_addr   = CW'(i_byte_addr);
                    n_pend   = 1'b0;
                    n_second = 1'b0;
                    unique case (t_func'(i_func))
                        FN_WR8: begin
                            n_data = {i_write_data[7:0], 24'd0};
                            n_cnt  = 3'd1;
                        end
                        FN_WR16: begin
                            n_data = {i_write_data[15:0], 16'd0};
                            n_cnt  = 3'd2;
                        end
                        FN_WR32: begin
                            n_data = i_write_data;
                            n_cnt  = 3'd4;
                        end
                        FN_RD8: begin
                            n_data = '0;
                            n_cnt  = 3'd1;
                        end
                        FN_RD16: begin
                            n_data = '0;
                            n_cnt  = 3'd2;
                        end
                        FN_RD32: begin
                            n_data = '0;
                            n_cnt  = 3'd4;
                        end
                        default: begin
                            n_data = '0;
                            n_cnt  = 3'd1;
                        end
                    endcase
                end
            end
            // subtract the size until the address lies inside the store
            ST_REDUCE: begin
                o_alu_a = r_addr;
                o_alu_b = '0;
                if (i_alu_wrap) begin
                    n_addr = i_alu_sum;
                end else begin
                    n_ptr   = r_addr[AW-1:0];
                    n_start = r_addr[AW-1:0];
                    n_ent   = {r_addr[AW-1:1], 1'b0};
                end
            end
            // one byte per cycle, most significant first
            ST_WRITE: begin
                o_ram_we = 1'b1;
                n_data   = {r_data[DATA_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                n_ptr    = i_alu_sum[AW-1:0];
                n_cnt    = r_cnt - 3'd1;
            end
            // issue byte reads, shift in data of the previous one
            ST_READ: begin
                if (r_pend) begin
                    n_data = {r_data[DATA_W-BYTE_W-1:0], i_ram_rdata};
                end
                n_pend = 1'b1;
                n_ptr  = i_alu_sum[AW-1:0];
                n_cnt  = r_cnt - 3'd1;
            end
            // last byte arrives, send the read beat
            ST_RFIN: begin
                n_pend            = 1'b0;
                n_valid           = 1'b1;
                n_res             = '0;
                n_res.read_data   = {r_data[DATA_W-BYTE_W-1:0], i_ram_rdata};
                n_res.last        = 1'b1;
            end
            // read high byte of the entry, form address of the low byte
            ST_EREQ: begin
                o_alu_a    = CW'(r_ent);
                o_ram_addr = r_ent;
                n_ptr      = i_alu_sum[AW-1:0];
            end
            ST_EHI: begin
                o_ram_addr = r_ptr;
                n_hi       = i_ram_rdata;
            end
            // low byte arrives: convert, and point at the second entry
            ST_ELO: begin
                o_alu_a           = CW'(r_start);
                o_alu_b           = CW'(2'd2);
                n_ent             = {i_alu_sum[AW-1:1], 1'b0};
                n_second          = 1'b1;
                n_valid           = 1'b1;
                n_res             = '0;
                n_res.color_valid = 1'b1;
                n_res.entry_addr  = ent_wide[ADDR_W-1:0];
                n_res.red         = rgb[3*COLOR_W-1 -: COLOR_W];
                n_res.green       = rgb[2*COLOR_W-1 -: COLOR_W];
                n_res.blue        = rgb[COLOR_W-1:0];
                n_res.last        = !((r_func == FN_WR32) && !r_second);
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ptr    <= '0;
            r_pend   <= 1'b0;
            r_second <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_pend   <= n_pend;
            r_second <= n_second;
            r_valid  <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_data  <= n_data;
        r_addr  <= n_addr;
        r_start <= n_start;
        r_ent   <= n_ent;
        r_cnt   <= n_cnt;
        r_hi    <= n_hi;
        r_res   <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/palette_ram_color_convert.sv -----
// Top level: byte-addressed palette RAM with RGB444+3 to RGB555 conversion.
`timescale 1ns / 1ps

// Accepts an access when start is high and busy is low, then stays busy until
// its last result beat is out. Results are one-cycle strobes on o_valid and
// cannot be held off. All work runs through one RAM port and one wrapping
// index adder, one byte a cycle once an address at or above the palette size
// has been reduced by subtracting the size. Busy falls in the cycle that
// carries the last beat. After reset the block clears the store and holds
// busy high until the clear is done. Codes 6 and 7 are not accepted.

module palette_ram_color_convert #(
    parameter int PALETTE_BYTES = prc_pkg::PALETTE_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [2:0]                   i_func,
    input  logic [prc_pkg::ADDR_W-1:0]   i_byte_addr,
    input  logic [prc_pkg::DATA_W-1:0]   i_write_data,
    output logic                         busy,
    output logic                         o_valid,
    output logic [prc_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_color_valid,
    output logic [prc_pkg::ADDR_W-1:0]   o_entry_addr,
    output logic [prc_pkg::COLOR_W-1:0]  o_red,
    output logic [prc_pkg::COLOR_W-1:0]  o_green,
    output logic [prc_pkg::COLOR_W-1:0]  o_blue,
    output logic                         o_last
);

    import prc_pkg::*;

    localparam int AW = $clog2(PALETTE_BYTES);
    localparam int CW = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;

    logic [CW-1:0]     alu_a;
    logic [CW-1:0]     alu_b;
    logic [CW-1:0]     alu_sum;
    logic              alu_wrap;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    t_result           res;

    // sequencer
    prc_ctrl #(
        .AW            (AW),
        .CW            (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_func       (i_func),
        .i_byte_addr  (i_byte_addr),
        .i_write_data (i_write_data),
        .busy         (busy),
        .o_alu_a      (alu_a),
        .o_alu_b      (alu_b),
        .i_alu_sum    (alu_sum),
        .i_alu_wrap   (alu_wrap),
        .o_ram_we     (ram_we),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .i_ram_rdata  (ram_rdata),
        .o_valid      (o_valid),
        .o_res        (res)
    );

    // shared wrapping index adder
    prc_alu #(
        .PALETTE_BYTES (PALETTE_BYTES),
        .W             (CW)
    ) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_sum  (alu_sum),
        .o_wrap (alu_wrap)
    );

    // palette store
    prc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PALETTE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // result fields
    assign o_read_data   = res.read_data;
    assign o_color_valid = res.color_valid;
    assign o_entry_addr  = res.entry_addr;
    assign o_red         = res.red;
    assign o_green       = res.green;
    assign o_blue        = res.blue;
    assign o_last        = res.last;

endmodule
